>>> rtl/fib_fd_pkg.sv
package fib_fd_pkg;

   localparam int unsigned VALUE_BITS = 64;
   localparam int unsigned HALF_BITS  = 32;
   localparam int unsigned REQ_BITS   = 32;
   localparam int unsigned STEP_W     = 4;

   localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef enum logic {
      XS_A,
      XS_B
   } xsel_type;

   typedef enum logic [1:0] {
      YS_A,
      YS_B,
      YS_T
   } ysel_type;

   typedef enum logic [1:0] {
      PT_LL,
      PT_LH,
      PT_HL
   } part_type;

   typedef enum logic {
      DS_ODD,
      DS_EVEN
   } dst_type;

   typedef enum logic [2:0] {
      AC_NONE,
      AC_LOAD,
      AC_LO,
      AC_HI,
      AC_HI2
   } acc_type;

   typedef enum logic {
      SQ_NEXT,
      SQ_UPDATE
   } seq_type;

   typedef struct packed {
      logic     mul_en;
      xsel_type x_sel;
      ysel_type y_sel;
      part_type part;
      dst_type  dst;
      acc_type  acc;
      logic     t_load;
      seq_type  seq;
   } ucode_type;

   // One doubling step: the two squares are summed into the odd term, the
   // product a*(2b-a) into the even term, and the last word applies the step.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{mul_en: 1'b0, x_sel: XS_A, y_sel: YS_A, part: PT_LL, dst: DS_ODD,
            acc: AC_NONE, t_load: 1'b0, seq: SQ_NEXT};
      case (step)
         4'd0: begin
            w.mul_en = 1'b1; w.x_sel = XS_A; w.y_sel = YS_A; w.part = PT_LL;
            w.t_load = 1'b1;
         end
         4'd1: begin
            w.mul_en = 1'b1; w.x_sel = XS_A; w.y_sel = YS_A; w.part = PT_LH;
            w.dst = DS_ODD; w.acc = AC_LOAD;
         end
         4'd2: begin
            w.mul_en = 1'b1; w.x_sel = XS_B; w.y_sel = YS_B; w.part = PT_LL;
            w.dst = DS_ODD; w.acc = AC_HI2;
         end
         4'd3: begin
            w.mul_en = 1'b1; w.x_sel = XS_B; w.y_sel = YS_B; w.part = PT_LH;
            w.dst = DS_ODD; w.acc = AC_LO;
         end
         4'd4: begin
            w.mul_en = 1'b1; w.x_sel = XS_A; w.y_sel = YS_T; w.part = PT_LL;
            w.dst = DS_ODD; w.acc = AC_HI2;
         end
         4'd5: begin
            w.mul_en = 1'b1; w.x_sel = XS_A; w.y_sel = YS_T; w.part = PT_LH;
            w.dst = DS_EVEN; w.acc = AC_LOAD;
         end
         4'd6: begin
            w.mul_en = 1'b1; w.x_sel = XS_A; w.y_sel = YS_T; w.part = PT_HL;
            w.dst = DS_EVEN; w.acc = AC_HI;
         end
         4'd7: begin
            w.dst = DS_EVEN; w.acc = AC_HI;
         end
         4'd8: begin
            w.seq = SQ_UPDATE;
         end
         default: begin
            w.seq = SQ_UPDATE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/fibonacci_fast_doubling_unit.sv
// Returns F(n) modulo 2^64 for an unsigned index n, one item at a time. The
// index bits are walked from bit INDEX_BITS-1 down to bit 0, and each bit runs
// a nine-word microprogram on one shared 32x32 multiplier: three partial
// products per 64-bit multiply, squares done in two, plus an accumulate
// slot and an update word. The result becomes valid in the cycle after the
// last update word, and the next item is accepted in that same cycle at the
// earliest, as soon as the program has finished, even while the previous
// result is still waiting to be taken. A new result that is ready while the
// previous one still waits holds the program on its update word until the
// previous one is taken.
module fibonacci_fast_doubling_unit #(
   parameter int unsigned INDEX_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fib_fd_pkg::REQ_BITS-1:0]     req_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fib_fd_pkg::VALUE_BITS-1:0]   rsp_fib_value
);

   import fib_fd_pkg::*;

   localparam int unsigned CNT_W = $clog2(INDEX_BITS);

   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       pc_ff, pc_in;
   logic [CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [INDEX_BITS-1:0]   n_ff, n_in;
   logic [VALUE_BITS-1:0]   a_ff, a_in;
   logic [VALUE_BITS-1:0]   b_ff, b_in;
   logic [VALUE_BITS-1:0]   t_ff, t_in;
   logic [VALUE_BITS-1:0]   prod_ff, prod_in;
   logic [VALUE_BITS-1:0]   even_ff, even_in;
   logic [VALUE_BITS-1:0]   odd_ff, odd_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff, rsp_value_in;

   ucode_type               word;
   logic [VALUE_BITS-1:0]   x_op, y_op, acc_cur, acc_new, step_a, step_b;
   logic [HALF_BITS-1:0]    mx, my;
   logic                    last_bit, hold;

   always_comb begin
      word = ucode_rom(pc_ff);

      case (word.x_sel)
         XS_A:    x_op = a_ff;
         XS_B:    x_op = b_ff;
         default: x_op = a_ff;
      endcase
      case (word.y_sel)
         YS_A:    y_op = a_ff;
         YS_B:    y_op = b_ff;
         YS_T:    y_op = t_ff;
         default: y_op = a_ff;
      endcase
      mx = (word.part == PT_HL) ? x_op[VALUE_BITS-1:HALF_BITS] : x_op[HALF_BITS-1:0];
      my = (word.part == PT_LH) ? y_op[VALUE_BITS-1:HALF_BITS] : y_op[HALF_BITS-1:0];

      acc_cur = (word.dst == DS_EVEN) ? even_ff : odd_ff;
      case (word.acc)
         AC_LOAD: acc_new = prod_ff;
         AC_LO:   acc_new = acc_cur + prod_ff;
         AC_HI:   acc_new = acc_cur + {prod_ff[HALF_BITS-1:0], {HALF_BITS{1'b0}}};
         AC_HI2:  acc_new = acc_cur + {prod_ff[HALF_BITS-2:0], {(HALF_BITS+1){1'b0}}};
         default: acc_new = acc_cur;
      endcase

      if (n_ff[bit_cnt_ff]) begin
         step_a = odd_ff;
         step_b = even_ff + odd_ff;
      end else begin
         step_a = even_ff;
         step_b = odd_ff;
      end

      last_bit = (bit_cnt_ff == '0);
      hold     = (word.seq == SQ_UPDATE) && last_bit && rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      bit_cnt_in   = bit_cnt_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      even_in      = even_ff;
      odd_in       = odd_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               n_in       = INDEX_BITS'(req_index);
               a_in       = '0;
               b_in       = VALUE_BITS'(1);
               pc_in      = STEP_FIRST;
               bit_cnt_in = CNT_W'(INDEX_BITS - 1);
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!hold) begin
               if (word.mul_en) begin
                  prod_in = {{HALF_BITS{1'b0}}, mx} * {{HALF_BITS{1'b0}}, my};
               end
               if (word.t_load) begin
                  t_in = {b_ff[VALUE_BITS-2:0], 1'b0} - a_ff;
               end
               if (word.acc != AC_NONE) begin
                  if (word.dst == DS_EVEN) begin
                     even_in = acc_new;
                  end else begin
                     odd_in = acc_new;
                  end
               end
               if (word.seq == SQ_UPDATE) begin
                  a_in  = step_a;
                  b_in  = step_b;
                  pc_in = STEP_FIRST;
                  if (last_bit) begin
                     rsp_value_in = step_a;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     bit_cnt_in = bit_cnt_ff - 1'b1;
                  end
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= STEP_FIRST;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      even_ff      <= even_in;
      odd_ff       <= odd_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fib_value = rsp_value_ff;

endmodule
